[rtl/core/der_tlv_structure_walker_assert.svh]
// ----------------------------------------------------------------------------
// DER TLV walker assertion macros
// Shared concurrent assertion forms for the walker modules.
// ----------------------------------------------------------------------------
`ifndef DER_TLV_STRUCTURE_WALKER_ASSERT_SVH
`define DER_TLV_STRUCTURE_WALKER_ASSERT_SVH

// same-cycle implication
`define DTW_ASSERT_IMPL(label, clk, rst, ante, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (conseq)) \
      else $error("walker assertion failed");

// next-cycle implication
`define DTW_ASSERT_NEXT(label, clk, rst, ante, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (conseq)) \
      else $error("walker assertion failed");

`endif

[rtl/core/dtw_pkg.sv]
// ----------------------------------------------------------------------------
// DER TLV walker package
// Sizes, codes and the command, status and result structs of the walker.
// ----------------------------------------------------------------------------
package dtw_pkg;

   localparam int DEPTH     = 8;
   localparam int LEN_BYTES = 4;
   localparam int TAG_BITS  = 28;
   localparam int LEN_W     = 32;
   localparam int LVL_W     = $clog2(DEPTH + 1);
   localparam int LEFT_W    = $clog2(LEN_BYTES + 1);

   localparam logic [1:0]          CLASS_UNIVERSAL = 2'd0;
   localparam logic [4:0]          TAG_LONG_FORM   = 5'h1f;
   localparam logic [6:0]          LEN_COUNT_RSVD  = 7'h7f;
   localparam logic [TAG_BITS-1:0] TAG_SEQUENCE    = TAG_BITS'(16);
   localparam logic [TAG_BITS-1:0] TAG_SET         = TAG_BITS'(17);

   typedef enum logic [2:0] {
      PH_TAG_FIRST,
      PH_TAG_MORE,
      PH_LEN_FIRST,
      PH_LEN_MORE,
      PH_CONTENT
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_TAG,
      ROLE_LEN,
      ROLE_CONTENT,
      ROLE_IGNORED
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_COUNT_RSVD,
      ERR_TOO_WIDE,
      ERR_EXCEEDS,
      ERR_PAST_END,
      ERR_TOO_DEEP,
      ERR_PRIM_SEQ
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_CLOSE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic pop;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic close_req;
      logic can_pop;
   } sts_type;

   typedef struct packed {
      role_type            role;
      logic                hdr;
      logic [1:0]          tag_class;
      logic                cons;
      logic [TAG_BITS-1:0] tag;
      logic [LEN_W-1:0]    elen;
      logic [7:0]          cbyte;
      logic [LVL_W-1:0]    depth;
      logic [LVL_W-1:0]    closed;
      logic                done;
      err_type             err;
   } rsp_type;

endpackage

[rtl/core/dtw_ctrl.sv]
// ----------------------------------------------------------------------------
// DER TLV walker controller
// Sequences accept, parse step, level closing and result hand-off.
// ----------------------------------------------------------------------------
`include "der_tlv_structure_walker_assert.svh"

module dtw_ctrl
   import dtw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = sts.close_req ? ST_CLOSE : ST_EMIT;
         end
         ST_CLOSE: begin
            if (!sts.can_pop) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !reset;
      cmd.accept = req_tready && req_tvalid;
      cmd.step   = (state_ff == ST_STEP);
      cmd.pop    = (state_ff == ST_CLOSE) && sts.can_pop;
      cmd.emit   = (state_ff == ST_EMIT) && out_free;
      valid_in   = cmd.emit || (valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   `DTW_ASSERT_NEXT(a_accept_steps, clock, reset, cmd.accept, state_ff == ST_STEP)
   `DTW_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, valid_ff)
   `DTW_ASSERT_NEXT(a_close_exits, clock, reset, state_ff == ST_CLOSE && !sts.can_pop, state_ff == ST_EMIT)

endmodule

[rtl/core/dtw_datapath.sv]
// ----------------------------------------------------------------------------
// DER TLV walker datapath
// Header decode, level stack of remaining counts, sticky error, result regs.
// ----------------------------------------------------------------------------
`include "der_tlv_structure_walker_assert.svh"

module dtw_datapath
   import dtw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [7:0]       in_byte,
   input  logic             in_start,
   input  logic [LEN_W-1:0] in_mlen,
   output rsp_type          rsp
);

   // parse state
   phase_type           phase_ff, phase_in;
   logic [1:0]          tclass_ff, tclass_in;
   logic                cons_ff, cons_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [LEN_W-1:0]    acc_ff, acc_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [LEN_W-1:0]    rem_ff [DEPTH+1];
   logic [LEN_W-1:0]    rem_in [DEPTH+1];
   logic [LVL_W-1:0]    open_ff, open_in;
   err_type             err_ff, err_in;

   // per-request payload
   logic [7:0]          byte_ff, byte_in;
   role_type            role_ff, role_in;
   logic                hdr_ff, hdr_in;
   logic [LEN_W-1:0]    elen_ff, elen_in;
   logic [7:0]          cbyte_ff, cbyte_in;
   logic [LVL_W-1:0]    closed_ff, closed_in;
   rsp_type             out_ff, out_in;

   logic [LEN_W-1:0]    cur;
   logic [LEN_W-1:0]    len_sel;
   logic                len_ge_cur;
   logic [LEN_W-1:0]    rem_sub;
   logic [LVL_W-1:0]    open_inc;

   assign cur        = rem_ff[open_ff];
   assign len_sel    = (phase_ff == PH_LEN_MORE) ? {acc_ff[LEN_W-9:0], byte_ff} :
                       (byte_ff[7] ? '0 : LEN_W'(byte_ff));
   assign len_ge_cur = (len_sel >= cur);
   // cur - 1 - len
   assign rem_sub    = cur + ~len_sel;
   assign open_inc   = open_ff + 1'b1;

   always_comb begin
      logic                tag_check;
      logic                finish;
      logic [LEN_W-1:0]    acc_dec;
      logic [LEFT_W-1:0]   left_dec;
      logic [6:0]          cnt;

      tag_check = 1'b0;
      finish    = 1'b0;
      acc_dec   = (acc_ff != '0) ? acc_ff - 1'b1 : acc_ff;
      left_dec  = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
      cnt       = byte_ff[6:0];

      phase_in  = phase_ff;
      tclass_in = tclass_ff;
      cons_in   = cons_ff;
      tag_in    = tag_ff;
      acc_in    = acc_ff;
      left_in   = left_ff;
      rem_in    = rem_ff;
      open_in   = open_ff;
      err_in    = err_ff;
      byte_in   = byte_ff;
      role_in   = role_ff;
      hdr_in    = hdr_ff;
      elen_in   = elen_ff;
      cbyte_in  = cbyte_ff;
      closed_in = closed_ff;
      sts.close_req = 1'b0;
      sts.can_pop   = (open_ff != '0) && (cur == '0);

      if (cmd.accept) begin
         byte_in = in_byte;
         if (in_start) begin
            phase_in  = PH_TAG_FIRST;
            tclass_in = '0;
            cons_in   = 1'b0;
            tag_in    = '0;
            acc_in    = '0;
            left_in   = '0;
            for (int i = 0; i <= DEPTH; i++) rem_in[i] = '0;
            rem_in[0] = in_mlen;
            open_in   = '0;
            err_in    = ERR_NONE;
         end
      end else if (cmd.step) begin
         role_in   = ROLE_IGNORED;
         hdr_in    = 1'b0;
         elen_in   = '0;
         cbyte_in  = '0;
         closed_in = '0;
         if (err_ff == ERR_NONE) begin
            if (phase_ff == PH_CONTENT) begin
               role_in  = ROLE_CONTENT;
               cbyte_in = byte_ff;
               acc_in   = acc_dec;
               if (acc_dec == '0) begin
                  phase_in      = PH_TAG_FIRST;
                  sts.close_req = 1'b1;
               end
            end else begin
               role_in = (phase_ff == PH_TAG_FIRST || phase_ff == PH_TAG_MORE) ?
                         ROLE_TAG : ROLE_LEN;
               if (cur == '0) begin
                  err_in = ERR_PAST_END;
               end else begin
                  rem_in[open_ff] = cur - 1'b1;
                  case (phase_ff)
                     PH_TAG_FIRST: begin
                        tclass_in = byte_ff[7:6];
                        cons_in   = byte_ff[5];
                        if (byte_ff[4:0] == TAG_LONG_FORM) begin
                           tag_in   = '0;
                           phase_in = PH_TAG_MORE;
                        end else begin
                           tag_in    = TAG_BITS'(byte_ff[4:0]);
                           tag_check = 1'b1;
                        end
                     end
                     PH_TAG_MORE: begin
                        tag_in    = {tag_ff[TAG_BITS-8:0], byte_ff[6:0]};
                        tag_check = !byte_ff[7];
                     end
                     PH_LEN_FIRST: begin
                        if (!byte_ff[7]) begin
                           finish = 1'b1;
                        end else if (cnt == LEN_COUNT_RSVD) begin
                           err_in = ERR_COUNT_RSVD;
                        end else if (cnt > 7'(LEN_BYTES)) begin
                           err_in = ERR_TOO_WIDE;
                        end else if (cnt == '0) begin
                           finish = 1'b1;
                        end else begin
                           acc_in   = '0;
                           left_in  = cnt[LEFT_W-1:0];
                           phase_in = PH_LEN_MORE;
                        end
                     end
                     PH_LEN_MORE: begin
                        acc_in  = len_sel;
                        left_in = left_dec;
                        finish  = (left_dec == '0);
                     end
                     default: ;
                  endcase

                  // a primitive universal Sequence or Set is malformed
                  if (tag_check) begin
                     if (!cons_in && tclass_in == CLASS_UNIVERSAL &&
                         (tag_in == TAG_SEQUENCE || tag_in == TAG_SET))
                        err_in = ERR_PRIM_SEQ;
                     else
                        phase_in = PH_LEN_FIRST;
                  end

                  if (finish) begin
                     if (len_ge_cur) begin
                        err_in = ERR_EXCEEDS;
                     end else if (cons_ff && open_ff >= LVL_W'(DEPTH)) begin
                        err_in = ERR_TOO_DEEP;
                     end else begin
                        rem_in[open_ff] = rem_sub;
                        hdr_in  = 1'b1;
                        elen_in = len_sel;
                        if (cons_ff) begin
                           // push a level holding the element's length
                           open_in          = open_inc;
                           rem_in[open_inc] = len_sel;
                           phase_in         = PH_TAG_FIRST;
                           sts.close_req    = 1'b1;
                        end else if (len_sel == '0) begin
                           phase_in      = PH_TAG_FIRST;
                           sts.close_req = 1'b1;
                        end else begin
                           acc_in   = len_sel;
                           phase_in = PH_CONTENT;
                        end
                     end
                  end
               end
            end
         end
      end else if (cmd.pop) begin
         open_in   = open_ff - 1'b1;
         closed_in = closed_ff + 1'b1;
      end
   end

   always_comb begin
      out_in           = out_ff;
      out_in.role      = role_ff;
      out_in.hdr       = hdr_ff;
      out_in.tag_class = tclass_ff;
      out_in.cons      = cons_ff;
      out_in.tag       = tag_ff;
      out_in.elen      = elen_ff;
      out_in.cbyte     = cbyte_ff;
      out_in.depth     = open_ff;
      out_in.closed    = closed_ff;
      out_in.done      = (err_ff == ERR_NONE) && (phase_ff == PH_TAG_FIRST) &&
                         (open_ff == '0) && (rem_ff[0] == '0);
      out_in.err       = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG_FIRST;
         tclass_ff <= '0;
         cons_ff   <= 1'b0;
         tag_ff    <= '0;
         acc_ff    <= '0;
         left_ff   <= '0;
         for (int i = 0; i <= DEPTH; i++) rem_ff[i] <= '0;
         open_ff   <= '0;
         err_ff    <= ERR_NONE;
      end else begin
         phase_ff  <= phase_in;
         tclass_ff <= tclass_in;
         cons_ff   <= cons_in;
         tag_ff    <= tag_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         rem_ff    <= rem_in;
         open_ff   <= open_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      role_ff   <= role_in;
      hdr_ff    <= hdr_in;
      elen_ff   <= elen_in;
      cbyte_ff  <= cbyte_in;
      closed_ff <= closed_in;
      if (cmd.emit) out_ff <= out_in;
   end

   assign rsp = out_ff;

   `DTW_ASSERT_NEXT(a_pop_decrements, clock, reset, cmd.pop, open_ff == $past(open_ff) - 1'b1)
   `DTW_ASSERT_IMPL(a_depth_bound, clock, reset, cmd.step, open_ff <= LVL_W'(DEPTH))
   `DTW_ASSERT_NEXT(a_error_holds, clock, reset, cmd.step && err_ff != ERR_NONE, err_ff == $past(err_ff))

endmodule

[rtl/core/der_tlv_structure_walker.sv]
// ----------------------------------------------------------------------------
// DER TLV structure walker
// Walks a DER byte stream and reports tag, length and nesting per byte.
// ----------------------------------------------------------------------------
// Request channel (req_*): one message byte per request; req_tuser (start) on
// the first byte clears the level stack and any pending error, and carries the
// total message length in req_tdata[39:8]. Response channel (rsp_*): exactly
// one response per request, in order; rsp_tlast flags a fully consumed message.
// After acceptance the byte passes the step state and then the emit state,
// which registers the response. A byte that may close levels (the last
// content byte, or a constructed or empty header) passes the close state in
// between, which tests the innermost level and pops each constructed level
// it closes (the controller pops one level per cycle). The next request is
// accepted once the previous response is registered; if the receiver
// stalls, that response holds, the following one waits in the walker and
// the request channel stays blocked.
// Reset (synchronous, active high) empties the stack, clears the error and
// drops any response not yet taken; bytes before the first start are
// flagged as running past the end.
// ----------------------------------------------------------------------------
module der_tlv_structure_walker
   import dtw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], message_length[39:8]
   input  logic        req_tuser,   // start_req[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tag_class[1:0], is_constructed[2], tag_number[30:3], element_length[62:31],
   // content_byte[70:63], nesting_depth[74:71], levels_closed[78:75],
   // error_code[81:79], zero[87:82]
   output logic [87:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // byte_role[1:0], header_done[2]
   output logic        rsp_tlast    // message_done
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp;

   dtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dtw_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .in_byte  (req_tdata[7:0]),
      .in_start (req_tuser),
      .in_mlen  (req_tdata[39:8]),
      .rsp      (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.err, rsp.closed, rsp.depth, rsp.cbyte, rsp.elen,
                       rsp.tag, rsp.cons, rsp.tag_class};
   assign rsp_tuser = {rsp.hdr, rsp.role};
   assign rsp_tlast = rsp.done;

endmodule
